// ----- design/tlrf_pkg.sv -----
// ----------------------------------------------------------------------------
// Tank level report framer package
// Shared constants, the frame descriptor type and the framing functions.
// ----------------------------------------------------------------------------
package tlrf_pkg;

   localparam int FrameLen  = 32;
   localparam int IdxW      = $clog2(FrameLen);
   localparam int QDepth    = 2;
   localparam int QPtrW     = (QDepth > 1) ? $clog2(QDepth) : 1;
   localparam int QCntW     = $clog2(QDepth + 1);
   localparam int CsrIdxW   = 8;
   localparam int CsrDataW  = 16;

   localparam logic [IdxW-1:0] LastIdx = IdxW'(FrameLen - 1);

   // Register indexes of the configuration port.
   localparam logic [CsrIdxW-1:0] RegTankId    = 8'd0;
   localparam logic [CsrIdxW-1:0] RegPaired    = 8'd1;
   localparam logic [CsrIdxW-1:0] RegHeartbeat = 8'd2;
   localparam logic [CsrIdxW-1:0] RegLowBatt   = 8'd3;

   // Input actions.
   localparam logic ActWake  = 1'b0;
   localparam logic ActClear = 1'b1;

   // Frame header bytes.
   localparam logic [7:0] Sync0     = 8'hAA;
   localparam logic [7:0] Sync1     = 8'h55;
   localparam logic [7:0] FrameType = 8'h02;
   localparam logic [7:0] CrcPoly   = 8'h07;

   localparam logic [15:0] HeartbeatReset = 16'd1440;
   localparam logic [6:0]  LowBattReset   = 7'd20;
   localparam logic [15:0] CycleMax       = 16'hFFFF;

   typedef struct packed {
      logic [15:0] tank_id;
      logic [6:0]  level;
      logic [6:0]  battery;
      logic        low_batt;
      logic        fault;
      logic [31:0] seq;
   } frame_desc_type;

   function automatic logic [6:0] mask_level(input logic [3:0] m);
      logic [6:0] l;
      if (m[3])      l = 7'd100;
      else if (m[2]) l = 7'd75;
      else if (m[1]) l = 7'd50;
      else if (m[0]) l = 7'd25;
      else           l = 7'd0;
      return l;
   endfunction

   // A monotone mask is one of 0, 1, 3, 7, 15; anything else has a gap.
   function automatic logic mask_gap(input logic [3:0] m);
      logic [3:0] p;
      p = m + 4'd1;
      return (m & p) != 4'd0;
   endfunction

   // One byte of CRC-8, MSB first, no reflection.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
      logic [7:0] c;
      c = crc ^ d;
      for (int j = 0; j < 8; j++) begin
         if (c[7]) c = {c[6:0], 1'b0} ^ CrcPoly;
         else      c = {c[6:0], 1'b0};
      end
      return c;
   endfunction

   // Frame body bytes; the CRC byte is supplied separately.
   function automatic logic [7:0] frame_byte(input frame_desc_type d,
                                             input logic [IdxW-1:0] idx);
      logic [7:0] b;
      case (idx)
         5'd0:  b = Sync0;
         5'd1:  b = Sync1;
         5'd2:  b = FrameType;
         5'd3:  b = 8'(FrameLen);
         5'd4:  b = d.tank_id[7:0];
         5'd5:  b = d.tank_id[15:8];
         5'd6:  b = {1'b0, d.level};
         5'd7:  b = {1'b0, d.battery};
         5'd8:  b = {7'd0, d.low_batt};
         5'd9:  b = {7'd0, d.fault};
         5'd12: b = d.seq[7:0];
         5'd13: b = d.seq[15:8];
         5'd14: b = d.seq[23:16];
         5'd15: b = d.seq[31:24];
         default: b = 8'd0;
      endcase
      return b;
   endfunction

endpackage

// ----- design/tlrf_if.sv -----
// ----------------------------------------------------------------------------
// Tank level report framer channels
// Valid/ready interfaces for the wake input, the byte output and the CSR port.
// ----------------------------------------------------------------------------
interface tlrf_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [3:0] probes_first;
   logic [3:0] probes_second;
   logic [3:0] probes_third;
   logic [6:0] battery_percent;

   modport source (output valid, action, probes_first, probes_second, probes_third,
                   battery_percent, input ready);
   modport sink (input valid, action, probes_first, probes_second, probes_third,
                 battery_percent, output ready);
endinterface

interface tlrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic [4:0] byte_index;
   logic       last_byte;

   modport source (output valid, packet_byte, byte_index, last_byte, input ready);
   modport sink (input valid, packet_byte, byte_index, last_byte, output ready);
endinterface

interface tlrf_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- design/tlrf_front.sv -----
// ----------------------------------------------------------------------------
// Tank level report framer front end
// Holds the registers and report trackers, classifies each wake and queues
// a frame descriptor whenever a report is due.
// ----------------------------------------------------------------------------
module tlrf_front import tlrf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   tlrf_req_if.sink       req,
   tlrf_csr_if.sink       csr,
   input  logic           q_ready,
   output logic           q_push,
   output frame_desc_type q_desc
);

   logic [15:0] tank_id_ff, tank_id_in;
   logic        paired_ff, paired_in;
   logic [15:0] hb_ff, hb_in;
   logic [6:0]  thr_ff, thr_in;

   logic [31:0] seq_ff, seq_in;
   logic [6:0]  last_lvl_ff, last_lvl_in;
   logic        sent_ff, sent_in;
   logic [6:0]  batt_ff, batt_in;
   logic [15:0] cyc_ff, cyc_in;

   logic        accept, csr_wr;
   logic [6:0]  lvl_a, lvl_b, lvl_c, lvl_ab, level;
   logic        beat, send;
   logic [6:0]  batt_now;

   assign csr.ready = 1'b1;
   assign csr_wr    = csr.valid;

   // The queue always has room for a descriptor when an item is taken.
   assign req.ready = q_ready;
   assign accept    = req.valid & q_ready;

   always_comb begin
      lvl_a  = mask_level(req.probes_first);
      lvl_b  = mask_level(req.probes_second);
      lvl_c  = mask_level(req.probes_third);
      lvl_ab = (lvl_b > lvl_a) ? lvl_b : lvl_a;
      level  = (lvl_c > lvl_ab) ? lvl_c : lvl_ab;
      beat   = cyc_ff >= hb_ff;
      batt_now = (paired_ff && (!sent_ff || beat)) ? req.battery_percent : batt_ff;
      send   = accept && (req.action == ActWake) && paired_ff &&
               (!sent_ff || (level != last_lvl_ff) || beat);
   end

   assign q_push           = send;
   assign q_desc.tank_id   = tank_id_ff;
   assign q_desc.level     = level;
   assign q_desc.battery   = batt_now;
   assign q_desc.low_batt  = batt_now <= thr_ff;
   assign q_desc.fault     = mask_gap(req.probes_third);
   assign q_desc.seq       = seq_ff;

   always_comb begin
      tank_id_in  = tank_id_ff;
      paired_in   = paired_ff;
      hb_in       = hb_ff;
      thr_in      = thr_ff;
      seq_in      = seq_ff;
      last_lvl_in = last_lvl_ff;
      sent_in     = sent_ff;
      batt_in     = batt_ff;
      cyc_in      = cyc_ff;
      if (csr_wr) begin
         case (csr.index)
            RegTankId:    tank_id_in = csr.data;
            RegPaired:    paired_in  = csr.data[0];
            RegHeartbeat: hb_in      = csr.data;
            RegLowBatt:   thr_in     = csr.data[6:0];
            default: ;
         endcase
      end
      if (accept) begin
         if (req.action == ActClear) begin
            seq_in      = 32'd0;
            last_lvl_in = 7'd0;
            sent_in     = 1'b0;
         end else begin
            batt_in = batt_now;
            if (send) begin
               last_lvl_in = level;
               sent_in     = 1'b1;
               seq_in      = seq_ff + 32'd1;
               // Count restarts at zero and then grows with this wake.
               cyc_in      = 16'd1;
            end else if (cyc_ff != CycleMax) begin
               cyc_in = cyc_ff + 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tank_id_ff  <= 16'd0;
         paired_ff   <= 1'b0;
         hb_ff       <= HeartbeatReset;
         thr_ff      <= LowBattReset;
         seq_ff      <= 32'd0;
         last_lvl_ff <= 7'd0;
         sent_ff     <= 1'b0;
         batt_ff     <= 7'd0;
         cyc_ff      <= 16'd0;
      end else begin
         tank_id_ff  <= tank_id_in;
         paired_ff   <= paired_in;
         hb_ff       <= hb_in;
         thr_ff      <= thr_in;
         seq_ff      <= seq_in;
         last_lvl_ff <= last_lvl_in;
         sent_ff     <= sent_in;
         batt_ff     <= batt_in;
         cyc_ff      <= cyc_in;
      end
   end

   // A sent frame must leave the trackers marked as sent with its level.
   assert property (@(posedge clock) disable iff (reset)
      q_push |=> sent_ff && (last_lvl_ff == $past(level)))
      else $error("trackers not updated after frame");

endmodule

// ----- design/tlrf_queue.sv -----
// ----------------------------------------------------------------------------
// Tank level report framer descriptor queue
// Short FIFO of frame descriptors between the front end and the serializer.
// ----------------------------------------------------------------------------
module tlrf_queue import tlrf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  frame_desc_type push_desc,
   output logic           push_ready,
   input  logic           pop,
   output logic           head_valid,
   output frame_desc_type head_desc
);

   frame_desc_type         mem [QDepth];
   logic [QPtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]       cnt_ff, cnt_in;

   assign push_ready = cnt_ff != QCntW'(QDepth);
   assign head_valid = cnt_ff != '0;
   assign head_desc  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      cnt_in = cnt_ff + QCntW'(push) - QCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && !push_ready))
      else $error("descriptor pushed into a full queue");

   assert property (@(posedge clock) disable iff (reset) !(pop && !head_valid))
      else $error("descriptor popped from an empty queue");

endmodule

// ----- design/tlrf_back.sv -----
// ----------------------------------------------------------------------------
// Tank level report framer serializer
// Streams the head descriptor as 32 bytes, one per cycle while the output is ready, with running CRC-8.
// ----------------------------------------------------------------------------
module tlrf_back import tlrf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           head_valid,
   input  frame_desc_type head_desc,
   output logic           pop,
   tlrf_rsp_if.source     rsp
);

   logic [IdxW-1:0] idx_ff, idx_in;
   logic [7:0]      crc_ff, crc_in;
   logic            out_valid_ff, out_valid_in;
   logic [7:0]      out_byte_ff, out_byte_in;
   logic [IdxW-1:0] out_idx_ff;
   logic            out_last_ff;
   logic            load;
   logic [7:0]      body;

   assign load = head_valid && (!out_valid_ff || rsp.ready);
   assign pop  = load && (idx_ff == LastIdx);
   assign body = frame_byte(head_desc, idx_ff);

   always_comb begin
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      out_byte_in  = out_byte_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      if (load) begin
         out_valid_in = 1'b1;
         idx_in       = idx_ff + 1'b1;
         if (idx_ff == LastIdx) begin
            out_byte_in = crc_ff;
            crc_in      = 8'd0;
         end else begin
            out_byte_in = body;
            crc_in      = crc8_byte(crc_ff, body);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= out_byte_in;
         out_idx_ff  <= idx_ff;
         out_last_ff <= idx_ff == LastIdx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         crc_ff       <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.packet_byte = out_byte_ff;
   assign rsp.byte_index  = out_idx_ff;
   assign rsp.last_byte   = out_last_ff;

   // Each frame starts its CRC from zero.
   assert property (@(posedge clock) disable iff (reset)
      (load && idx_ff == '0) |-> crc_ff == 8'd0)
      else $error("CRC not cleared at frame start");

   // Inside a frame the bytes follow each other without a gap.
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && !rsp.last_byte) |=>
         rsp.valid && (rsp.byte_index == IdxW'($past(rsp.byte_index) + 1'b1)))
      else $error("frame bytes out of sequence");

endmodule

// ----- design/tank_level_report_framer.sv -----
// ----------------------------------------------------------------------------
// Tank level report framer
// Turns wake samples into 32-byte report frames streamed one byte per beat.
// ----------------------------------------------------------------------------
// The front end accepts one item per cycle and settles at once whether it
// produces a report. A report is a 32-byte frame that the serializer emits
// at one byte per cycle while the output is ready; a two-entry descriptor
// queue lets the front end take further items while a frame is still going
// out, and it holds back input only while one frame is going out and a
// second one is waiting behind it. Configuration writes are taken in any
// cycle.
module tank_level_report_framer import tlrf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tlrf_req_if.sink  req_bus,
   tlrf_rsp_if.source rsp_bus,
   tlrf_csr_if.sink  csr_bus
);

   logic           q_ready;
   logic           q_push;
   frame_desc_type q_desc;
   logic           head_valid;
   frame_desc_type head_desc;
   logic           pop;

   tlrf_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .csr    (csr_bus),
      .q_ready(q_ready),
      .q_push (q_push),
      .q_desc (q_desc)
   );

   tlrf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_desc),
      .push_ready(q_ready),
      .pop       (pop),
      .head_valid(head_valid),
      .head_desc (head_desc)
   );

   tlrf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_desc (head_desc),
      .pop       (pop),
      .rsp       (rsp_bus)
   );

endmodule
